// File: hw/rtl/hashed_bucket_insert_engine_defines.svh
// Assertion macros shared by the bucket insert engine RTL.
`ifndef HASHED_BUCKET_INSERT_ENGINE_DEFINES_SVH
`define HASHED_BUCKET_INSERT_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define HBIE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define HBIE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/hbie_pkg.sv
// Types and constants of the hashed bucket insert engine.
`default_nettype none

package hbie_pkg;

    localparam int KEY_W       = 24;
    localparam int PAY_W       = 64;
    localparam int CNT_W       = 13;
    localparam int SUM_W       = 20;   // holds 57 * sum of all digit weights
    localparam int DIG_MAX     = 8;    // decimal digits of a 24-bit key
    localparam int ASCII_ZERO  = 48;
    localparam int DIV10_SHIFT = 35;

    localparam logic [31:0]      DIV10_MUL = 32'hCCCC_CCCD;
    localparam logic [CNT_W-1:0] CNT_MAX   = '1;

    localparam logic [12:0] DIGIT_WEIGHT [0:6] = '{
        13'd730, 13'd641, 13'd1337, 13'd7921, 13'd121, 13'd135, 13'd233
    };

    typedef struct packed {
        logic [KEY_W-1:0] record_key;
        logic [PAY_W-1:0] record_payload;
    } hbie_req_t;

    typedef struct packed {
        logic [7:0]       home_bucket;
        logic [12:0]      stored_slot;
        logic [CNT_W-1:0] bucket_count;
        logic             spilled;
        logic [CNT_W-1:0] spill_total;
        logic             table_full;
    } hbie_rsp_t;

    typedef enum logic [1:0] {
        H_IDLE,
        H_DIGIT,
        H_WEIGHT,
        H_MOD
    } hbie_hash_state_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_SETUP,
        ST_PROBE,
        ST_FINISH
    } hbie_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/hbie_hash.sv
// Iterative key hash: digit extraction, weighted digit sum, reciprocal modulo.
`default_nettype none
`include "hashed_bucket_insert_engine_defines.svh"

module hbie_hash #(
    parameter int NUM_BUCKETS = 197,
    parameter int KEY_DIGITS  = 7,
    localparam int BK_W       = $clog2(NUM_BUCKETS)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       go,
    input  wire logic [hbie_pkg::KEY_W-1:0] key,
    output logic                            done,
    output logic [BK_W-1:0]                 bucket
);
    import hbie_pkg::*;

    // Modulo by reciprocal: the low MOD_K bits of sum * MOD_MUL hold the
    // scaled fraction, and the fraction times NUM_BUCKETS gives the remainder.
    localparam int MOD_K   = SUM_W + BK_W;
    localparam int MUL_W   = SUM_W + 1;
    localparam int PROD_W  = SUM_W + MUL_W;
    localparam int RPROD_W = MOD_K + BK_W;
    localparam logic [MUL_W-1:0] MOD_MUL =
        MUL_W'(((64'd1 << MOD_K) + 64'(NUM_BUCKETS - 1)) / 64'(NUM_BUCKETS));

    hbie_hash_state_t state_reg, state_next;
    logic [KEY_W-1:0] v_reg, v_next;
    logic [3:0]       n_reg, n_next;
    logic [2:0]       idx_reg, idx_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [BK_W-1:0]  rem_reg, rem_next;
    logic [MOD_K-1:0] frac_reg, frac_next;
    logic             mod_ph_reg, mod_ph_next;
    logic             done_reg, done_next;
    logic [3:0]       digs_reg [DIG_MAX];

    logic [55:0]        prod;
    logic [KEY_W-1:0]   quot;
    logic [KEY_W-1:0]   rem10;
    logic [3:0]         lim;
    logic [3:0]         dig_sel;
    logic [5:0]         ascii;
    logic [18:0]        term;
    logic [PROD_W-1:0]  mod_prod;
    logic [RPROD_W-1:0] rem_prod;
    logic               dig_we;

    // Divide by ten through the reciprocal; exact for any 24-bit value.
    assign prod    = 56'(v_reg) * 56'(DIV10_MUL);
    assign quot    = KEY_W'(prod >> DIV10_SHIFT);
    assign rem10   = v_reg - (quot << 3) - (quot << 1);

    assign lim     = (n_reg < 4'(KEY_DIGITS)) ? n_reg : 4'(KEY_DIGITS);
    assign dig_sel = digs_reg[3'(n_reg - 4'd1 - {1'b0, idx_reg})];
    assign ascii   = 6'(ASCII_ZERO) + {2'b00, dig_sel};
    assign term    = 19'(ascii) * 19'(DIGIT_WEIGHT[idx_reg]);

    assign mod_prod = PROD_W'(sum_reg) * PROD_W'(MOD_MUL);
    assign rem_prod = RPROD_W'(frac_reg) * RPROD_W'(NUM_BUCKETS);

    assign done   = done_reg;
    assign bucket = rem_reg;

    always_comb
    begin
        state_next  = state_reg;
        v_next      = v_reg;
        n_next      = n_reg;
        idx_next    = idx_reg;
        sum_next    = sum_reg;
        rem_next    = rem_reg;
        frac_next   = frac_reg;
        mod_ph_next = mod_ph_reg;
        done_next   = 1'b0;
        dig_we      = 1'b0;
        unique case (state_reg)
            H_IDLE:
            begin
                if (go)
                begin
                    v_next     = key;
                    n_next     = '0;
                    state_next = H_DIGIT;
                end
            end
            H_DIGIT:
            begin
                // Emit one digit, least significant first; a zero key gives one digit.
                dig_we = 1'b1;
                n_next = n_reg + 4'd1;
                v_next = quot;
                if (quot == '0)
                begin
                    idx_next   = '0;
                    sum_next   = '0;
                    state_next = H_WEIGHT;
                end
            end
            H_WEIGHT:
            begin
                // Weight the most significant digits first.
                sum_next = sum_reg + SUM_W'(term);
                idx_next = idx_reg + 3'd1;
                if ({1'b0, idx_reg} == lim - 4'd1)
                begin
                    mod_ph_next = 1'b0;
                    state_next  = H_MOD;
                end
            end
            H_MOD:
            begin
                if (!mod_ph_reg)
                begin
                    frac_next   = mod_prod[MOD_K-1:0];
                    mod_ph_next = 1'b1;
                end
                else
                begin
                    rem_next   = rem_prod[RPROD_W-1:MOD_K];
                    done_next  = 1'b1;
                    state_next = H_IDLE;
                end
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg      <= v_next;
        n_reg      <= n_next;
        idx_reg    <= idx_next;
        sum_reg    <= sum_next;
        rem_reg    <= rem_next;
        frac_reg   <= frac_next;
        mod_ph_reg <= mod_ph_next;
        if (dig_we)
        begin
            digs_reg[n_reg[2:0]] <= rem10[3:0];
        end
    end

    `HBIE_ASSERT_NOW(a_go_when_idle, go, state_reg == H_IDLE, "hash started while busy")
    `HBIE_ASSERT_NOW(a_bucket_range, done_reg,
        (BK_W+1)'(rem_reg) < (BK_W+1)'(NUM_BUCKETS), "bucket out of range")
    `HBIE_ASSERT_NOW(a_digit_count, state_reg == H_DIGIT, n_reg < 4'(DIG_MAX),
        "too many key digits")

endmodule

`default_nettype wire

// File: hw/rtl/hashed_bucket_insert_engine.sv
// Top level of the hashed bucket insert engine: slot table, probe sequencer, counters.
`default_nettype none
`include "hashed_bucket_insert_engine_defines.svh"

// Inserts one record per transaction into a bucketed hash table and reports
// where it went. After reset the engine sweeps the key table clear, one slot
// per cycle, through all NUM_BUCKETS * SLOTS_PER_BUCKET slots (6304 at defaults)
// with busy high. A transaction is taken when start is high and busy is low; the
// result follows with done high for exactly one cycle and cannot be stalled,
// so capture it when done is seen. Between accept and done the engine works through
// D key digits peeled off by the shared divide-by-ten step, W = min(D, KEY_DIGITS)
// weighted digits through the one weight multiplier, two reciprocal-multiply
// steps for the modulo, and P slots read one per cycle from the single key
// memory read port until an empty one is found or the table ends. A new
// transaction can start in the cycle that done is high.
module hashed_bucket_insert_engine #(
    parameter int NUM_BUCKETS      = 197,
    parameter int SLOTS_PER_BUCKET = 32,
    parameter int KEY_DIGITS       = 7
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire hbie_pkg::hbie_req_t  request,
    output logic                      done,
    output hbie_pkg::hbie_rsp_t       result
);
    import hbie_pkg::*;

    localparam int TABLE_SLOTS = NUM_BUCKETS * SLOTS_PER_BUCKET;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int PRB_W       = SLOT_W + 1;
    localparam int BK_W        = $clog2(NUM_BUCKETS);

    hbie_state_t      state_reg, state_next;
    logic [SLOT_W-1:0] clr_reg, clr_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [PAY_W-1:0]  pay_reg, pay_next;
    logic [BK_W-1:0]   bucket_reg, bucket_next;
    logic [PRB_W-1:0]  probe_reg, probe_next;
    logic              chk_vld_reg, chk_vld_next;
    logic [SLOT_W-1:0] chk_addr_reg, chk_addr_next;
    logic              found_reg, found_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]  overflow_reg, overflow_next;
    logic              done_reg, done_next;
    hbie_rsp_t         result_reg, result_next;

    logic [KEY_W-1:0]  key_mem [TABLE_SLOTS];
    logic [PAY_W-1:0]  pay_mem [TABLE_SLOTS];
    logic [CNT_W-1:0]  cnt_mem [NUM_BUCKETS];

    logic [KEY_W-1:0]  key_rd_reg;
    logic [CNT_W-1:0]  cnt_rd_reg;

    logic              key_rd_en;
    logic              key_we;
    logic [SLOT_W-1:0] key_wa;
    logic [KEY_W-1:0]  key_wd;
    logic              pay_we;
    logic              cnt_rd_en;
    logic              cnt_we;
    logic [BK_W-1:0]   cnt_wa;
    logic [CNT_W-1:0]  cnt_wd;
    logic [CNT_W-1:0]  cnt_new;
    logic              spill;

    logic              hash_go;
    logic              hash_done;
    logic [BK_W-1:0]   hash_bucket;

    hbie_hash #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .KEY_DIGITS  (KEY_DIGITS)
    ) u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (hash_go),
        .key    (request.record_key),
        .done   (hash_done),
        .bucket (hash_bucket)
    );

    assign busy    = (state_reg != ST_IDLE);
    assign hash_go = start && (state_reg == ST_IDLE);
    assign done    = done_reg;
    assign result  = result_reg;

    assign cnt_new = (cnt_rd_reg != CNT_MAX) ? cnt_rd_reg + CNT_W'(1) : cnt_rd_reg;
    assign spill   = (cnt_new > CNT_W'(SLOTS_PER_BUCKET));

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        key_next      = key_reg;
        pay_next      = pay_reg;
        bucket_next   = bucket_reg;
        probe_next    = probe_reg;
        chk_vld_next  = chk_vld_reg;
        chk_addr_next = chk_addr_reg;
        found_next    = found_reg;
        slot_next     = slot_reg;
        overflow_next = overflow_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        key_rd_en     = 1'b0;
        key_we        = 1'b0;
        key_wa        = slot_reg;
        key_wd        = key_reg;
        pay_we        = 1'b0;
        cnt_rd_en     = 1'b0;
        cnt_we        = 1'b0;
        cnt_wa        = bucket_reg;
        cnt_wd        = cnt_new;
        unique case (state_reg)
            ST_CLEAR:
            begin
                // Sweep the key table empty; bucket counts share the sweep.
                key_we   = 1'b1;
                key_wa   = clr_reg;
                key_wd   = '0;
                cnt_we   = (PRB_W'(clr_reg) < PRB_W'(NUM_BUCKETS));
                cnt_wa   = BK_W'(clr_reg);
                cnt_wd   = '0;
                clr_next = clr_reg + SLOT_W'(1);
                if (clr_reg == SLOT_W'(TABLE_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    key_next   = request.record_key;
                    pay_next   = request.record_payload;
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (hash_done)
                begin
                    bucket_next = hash_bucket;
                    state_next  = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                probe_next   = PRB_W'(bucket_reg) * PRB_W'(SLOTS_PER_BUCKET);
                chk_vld_next = 1'b0;
                cnt_rd_en    = 1'b1;
                state_next   = ST_PROBE;
            end
            ST_PROBE:
            begin
                // Read one slot per cycle; check the slot read in the cycle before.
                if (chk_vld_reg && (key_rd_reg == '0))
                begin
                    found_next = 1'b1;
                    slot_next  = chk_addr_reg;
                    state_next = ST_FINISH;
                end
                else if (chk_vld_reg && (chk_addr_reg == SLOT_W'(TABLE_SLOTS - 1)))
                begin
                    found_next = 1'b0;
                    state_next = ST_FINISH;
                end
                else if (probe_reg < PRB_W'(TABLE_SLOTS))
                begin
                    key_rd_en     = 1'b1;
                    chk_vld_next  = 1'b1;
                    chk_addr_next = probe_reg[SLOT_W-1:0];
                    probe_next    = probe_reg + PRB_W'(1);
                end
                else
                begin
                    chk_vld_next = 1'b0;
                end
            end
            ST_FINISH:
            begin
                key_we = found_reg;
                pay_we = found_reg;
                cnt_we = 1'b1;
                if (spill && (overflow_reg != CNT_MAX))
                begin
                    overflow_next = overflow_reg + CNT_W'(1);
                end
                result_next.home_bucket  = 8'(bucket_reg);
                result_next.stored_slot  = found_reg ? 13'(slot_reg) : 13'd0;
                result_next.bucket_count = cnt_new;
                result_next.spilled      = spill;
                result_next.spill_total  = (spill && (overflow_reg != CNT_MAX))
                                         ? overflow_reg + CNT_W'(1) : overflow_reg;
                result_next.table_full   = !found_reg;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            chk_vld_reg  <= 1'b0;
            found_reg    <= 1'b0;
            overflow_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            chk_vld_reg  <= chk_vld_next;
            found_reg    <= found_next;
            overflow_reg <= overflow_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        pay_reg      <= pay_next;
        bucket_reg   <= bucket_next;
        probe_reg    <= probe_next;
        chk_addr_reg <= chk_addr_next;
        slot_reg     <= slot_next;
        result_reg   <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_wa] <= key_wd;
        end
        if (key_rd_en)
        begin
            key_rd_reg <= key_mem[probe_reg[SLOT_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pay_we)
        begin
            pay_mem[slot_reg] <= pay_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        if (cnt_rd_en)
        begin
            cnt_rd_reg <= cnt_mem[bucket_reg];
        end
    end

    `HBIE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "no busy after accept")
    `HBIE_ASSERT_NEXT(a_finish_done, state_reg == ST_FINISH, done,
        "finish without result strobe")
    `HBIE_ASSERT_NOW(a_full_slot_zero, done && result.table_full, result.stored_slot == 13'd0,
        "dropped record reports a slot")
    `HBIE_ASSERT_NOW(a_probe_range, state_reg == ST_PROBE,
        probe_reg <= PRB_W'(TABLE_SLOTS), "probe past table end")

endmodule

`default_nettype wire
